FILE: sv/cmd_pkg.sv
// ----------------------------------------------------------------------------
// cmd_pkg: shared types and constants of the compressed message deframer
// Holds the message type codes, the byte class codes and the result beat.
// ----------------------------------------------------------------------------
package cmd_pkg;

  // Message type bytes that the deframer recognizes.
  localparam logic [7:0] TypeCompressed = 8'h6D;  // 'm'
  localparam logic [7:0] TypeSet        = 8'h6B;  // 'k'
  localparam logic [7:0] TypeAck        = 8'h7A;  // 'z'

  // Header is the type byte plus a four-byte length.
  localparam logic [2:0] HeaderLastCount = 3'd4;

  // Kind of the message being parsed.
  localparam logic [1:0] KindPlain      = 2'd0;
  localparam logic [1:0] KindCompressed = 2'd1;
  localparam logic [1:0] KindSet        = 2'd2;
  localparam logic [1:0] KindAck        = 2'd3;

  // Class given to each output byte.
  localparam logic [1:0] ClassPlain   = 2'd0;
  localparam logic [1:0] ClassPayload = 2'd1;
  localparam logic [1:0] ClassDrop    = 2'd2;

  // One result beat.
  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] byte_class;
    logic       message_end;
    logic       algorithm_valid;
    logic [7:0] algorithm_index;
    logic       switch_event;
    logic       restart_event;
    logic       frame_error;
  } result_t;

  // Body bytes of plain messages pass through, compressed bodies go to the
  // decompressor, and everything else is dropped.
  function automatic logic [1:0] class_of_kind(input logic [1:0] kind);
    logic [1:0] cls;
    case (kind)
      KindPlain:      cls = ClassPlain;
      KindCompressed: cls = ClassPayload;
      default:        cls = ClassDrop;
    endcase
    return cls;
  endfunction

endpackage

FILE: sv/cmd_byte_if.sv
// ----------------------------------------------------------------------------
// cmd_byte_if: received byte channel
// Valid/ready channel that carries one byte of the message stream per beat.
// ----------------------------------------------------------------------------
interface cmd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

FILE: sv/cmd_result_if.sv
// ----------------------------------------------------------------------------
// cmd_result_if: classified byte channel
// Valid/ready channel that carries one classified byte per beat.
// ----------------------------------------------------------------------------
interface cmd_result_if;
  logic             valid;
  logic             ready;
  cmd_pkg::result_t result;

  modport source (output valid, output result, input ready);
  modport sink   (input valid, input result, output ready);
endinterface

FILE: sv/compressed_message_deframer.sv
// ----------------------------------------------------------------------------
// compressed_message_deframer: byte-serial deframer for a compressed stream
// Classes every received byte and tracks the selected decompression method.
// ----------------------------------------------------------------------------
// The block takes one byte per clock and returns one classified byte per
// clock while the sink does not stall: a byte is captured in an input
// register, parsed against the frame state, and held in a result register
// until the sink takes it. Ready on the input follows the result register,
// so a full pipeline keeps streaming as long as the sink takes a beat in
// every cycle. The method count register must be written only while no beat
// is in flight; the block itself does not enforce this. Its reset value is 1.
module compressed_message_deframer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_wdata_i,
  cmd_byte_if.sink            in_i,
  cmd_result_if.source        out_o
);

  // Parser phase codes.
  localparam logic [1:0] PhHeader = 2'd0;
  localparam logic [1:0] PhBody   = 2'd1;
  localparam logic [1:0] PhIndex  = 2'd2;

  logic [7:0]  count_q;
  logic        s1_valid_q;
  logic [7:0]  s1_byte_q;
  logic        out_valid_q;
  cmd_pkg::result_t out_q;

  logic [1:0]  phase_q, phase_d;
  logic [2:0]  hcount_q, hcount_d;
  logic [1:0]  kind_q, kind_d;
  logic [31:0] acc_q, acc_d;
  logic [31:0] rem_q, rem_d;
  logic [7:0]  sel_q, sel_d;
  logic        sel_valid_q, sel_valid_d;

  logic        advance;
  logic        in_ready;
  cmd_pkg::result_t res;

  // Handshake: the parse stage moves on whenever the result register is free.
  assign advance  = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_ready = !s1_valid_q || !out_valid_q || out_o.ready;
  assign in_i.ready   = in_ready;
  assign out_o.valid  = out_valid_q;
  assign out_o.result = out_q;

  // Parse one byte against the frame state.
  always_comb begin
    phase_d     = phase_q;
    hcount_d    = hcount_q;
    kind_d      = kind_q;
    acc_d       = acc_q;
    rem_d       = rem_q;
    sel_d       = sel_q;
    sel_valid_d = sel_valid_q;

    res.out_byte        = s1_byte_q;
    res.byte_class      = cmd_pkg::ClassPlain;
    res.message_end     = 1'b0;
    res.switch_event    = 1'b0;
    res.restart_event   = 1'b0;
    res.frame_error     = 1'b0;

    case (phase_q)
      PhBody: begin
        res.byte_class = cmd_pkg::class_of_kind(kind_q);
        rem_d = rem_q - 32'd1;
        if (rem_q == 32'd1) begin
          res.message_end = 1'b1;
          phase_d = PhHeader;
        end
      end
      PhIndex: begin
        res.byte_class  = cmd_pkg::ClassDrop;
        res.message_end = 1'b1;
        phase_d = PhHeader;
        if (s1_byte_q >= count_q) begin
          res.frame_error = 1'b1;
        end else if (!sel_valid_q || s1_byte_q != sel_q) begin
          res.switch_event = 1'b1;
          sel_d = s1_byte_q;
          sel_valid_d = 1'b1;
        end
      end
      default: begin
        phase_d = PhHeader;
        if (hcount_q == 3'd0) begin
          // Type byte: decide the kind of the message.
          if (s1_byte_q == cmd_pkg::TypeCompressed) begin
            kind_d = cmd_pkg::KindCompressed;
          end else if (s1_byte_q == cmd_pkg::TypeSet) begin
            kind_d = cmd_pkg::KindSet;
          end else if (s1_byte_q == cmd_pkg::TypeAck) begin
            kind_d = cmd_pkg::KindAck;
          end else begin
            kind_d = cmd_pkg::KindPlain;
          end
          acc_d    = 32'd0;
          hcount_d = 3'd1;
          res.byte_class = (kind_d == cmd_pkg::KindPlain) ? cmd_pkg::ClassPlain
                                                          : cmd_pkg::ClassDrop;
        end else begin
          // Length bytes, most significant first.
          res.byte_class = (kind_q == cmd_pkg::KindPlain) ? cmd_pkg::ClassPlain
                                                          : cmd_pkg::ClassDrop;
          acc_d    = {acc_q[23:0], s1_byte_q};
          hcount_d = hcount_q + 3'd1;
          if (hcount_q == cmd_pkg::HeaderLastCount) begin
            hcount_d = 3'd0;
            if (acc_d < 32'd4) begin
              // A length too short to count itself ends the message here.
              res.frame_error = 1'b1;
              res.message_end = 1'b1;
            end else if (kind_q == cmd_pkg::KindSet) begin
              phase_d = PhIndex;
            end else begin
              if (kind_q == cmd_pkg::KindAck) begin
                res.restart_event = 1'b1;
                sel_valid_d = 1'b0;
                sel_d = 8'd0;
              end
              if (acc_d == 32'd4) begin
                res.message_end = 1'b1;
              end else begin
                rem_d = acc_d - 32'd4;
                phase_d = PhBody;
              end
            end
          end
        end
      end
    endcase

    res.algorithm_valid = sel_valid_d;
    res.algorithm_index = sel_d;
  end

  // Method count register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 8'd1;
    end else if (cfg_we_i) begin
      count_q <= cfg_wdata_i;
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      s1_byte_q <= in_i.data_byte;
    end
  end

  // Frame state, updated as each byte is parsed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhHeader;
      hcount_q    <= 3'd0;
      kind_q      <= cmd_pkg::KindPlain;
      acc_q       <= 32'd0;
      rem_q       <= 32'd0;
      sel_q       <= 8'd0;
      sel_valid_q <= 1'b0;
    end else if (advance) begin
      phase_q     <= phase_d;
      hcount_q    <= hcount_d;
      kind_q      <= kind_d;
      acc_q       <= acc_d;
      rem_q       <= rem_d;
      sel_q       <= sel_d;
      sel_valid_q <= sel_valid_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

endmodule
